/* sv/cbe_pkg.sv */
// Shared types and constants for the cubic Bezier easing bisection unit.
// No dependencies.
package cbe_pkg;

    localparam int unsigned Q_W = 17;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LOAD,
        PH_MID,
        PH_M0,
        PH_M1,
        PH_M2,
        PH_M3,
        PH_CMP,
        PH_OUT_Y,
        PH_OUT_LIN
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   sel_y;   // weight the bases with the y control values
    } t_dp_cmd;

    typedef struct packed {
        logic lin;       // both control points on the diagonal
        logic hit;       // curve x equals the target exactly
    } t_dp_stat;

endpackage

/* sv/cbe_ctrl.sv */
// Sequencer for the easing unit: bisection steps and the final y pass.
// Depends on cbe_pkg.
module cbe_ctrl #(
    parameter int ITERATIONS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cbe_pkg::t_dp_stat i_stat,
    output cbe_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import cbe_pkg::*;

    localparam int CntW = $clog2(ITERATIONS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_CMP,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [CntW-1:0] r_cnt;
    logic            r_ypass;

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ypass <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_MID;
                        r_cnt   <= '0;
                        r_ypass <= 1'b0;
                    end
                end
                S_MID: begin
                    if (i_stat.lin) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_M0;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= r_ypass ? S_OUT : S_CMP;
                S_CMP: begin
                    // exact hit or last step: keep t, evaluate y with the same bases
                    if (i_stat.hit || (r_cnt == CntW'(ITERATIONS))) begin
                        r_ypass <= 1'b1;
                        r_state <= S_M0;
                    end else begin
                        r_state <= S_MID;
                    end
                end
                S_OUT:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.sel_y = r_ypass;
        case (r_state)
            S_IDLE:  o_cmd.phase = i_start ? PH_LOAD : PH_IDLE;
            S_MID:   o_cmd.phase = i_stat.lin ? PH_OUT_LIN : PH_MID;
            S_M0:    o_cmd.phase = PH_M0;
            S_M1:    o_cmd.phase = PH_M1;
            S_M2:    o_cmd.phase = PH_M2;
            S_M3:    o_cmd.phase = PH_M3;
            S_CMP:   o_cmd.phase = PH_CMP;
            S_OUT:   o_cmd.phase = PH_OUT_Y;
            default: o_cmd.phase = PH_IDLE;
        endcase
    end

    a_accept_to_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_MID))
        else $error("accepted transfer did not start a search");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(ITERATIONS))
        else $error("step count past limit");

    a_no_cmp_in_ypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> !r_ypass)
        else $error("bracket update during y pass");

endmodule

/* sv/cbe_datapath.sv */
// Datapath: operand registers, bisection bracket, two shared 33x17 multipliers,
// Bernstein bases, weighted sum, compare and rounded result. Depends on cbe_pkg.
module cbe_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cbe_pkg::t_dp_cmd          i_cmd,
    input  logic [cbe_pkg::Q_W-1:0]   i_progress,
    input  logic [cbe_pkg::Q_W-1:0]   i_ctrl_a_x,
    input  logic [cbe_pkg::Q_W-1:0]   i_ctrl_a_y,
    input  logic [cbe_pkg::Q_W-1:0]   i_ctrl_b_x,
    input  logic [cbe_pkg::Q_W-1:0]   i_ctrl_b_y,
    output cbe_pkg::t_dp_stat         o_stat,
    output logic                      o_valid,
    output logic [cbe_pkg::Q_W-1:0]   o_eased
);
    import cbe_pkg::*;

    logic [16:0] r_x, r_ax, r_ay, r_bx, r_by;
    logic        r_lin;
    logic [16:0] r_top, r_bottom, r_t, r_r;
    logic [17:0] r_r3;      // 3*(1-t)
    logic [31:0] r_rt3;     // 3*r*t, Q.32
    logic [32:0] r_tt;      // t*t, Q.32
    logic [31:0] r_b1, r_b2;
    logic [32:0] r_b3;
    logic [48:0] r_pa, r_pb;
    logic [49:0] r_acc;
    logic [16:0] r_eased;
    logic        r_valid;

    logic [32:0] m0_a, m1_a;
    logic [16:0] m0_b, m1_b;
    logic [49:0] m0_p, m1_p;
    logic [16:0] coef_a, coef_b;
    logic [17:0] mid_sum;
    logic [16:0] t_n, r_n;
    logic [50:0] sum, target;
    logic [51:0] rnd;
    logic [19:0] y_q;

    assign coef_a = i_cmd.sel_y ? r_ay : r_ax;
    assign coef_b = i_cmd.sel_y ? r_by : r_bx;

    always_comb begin
        m0_a = '0;
        m0_b = '0;
        m1_a = '0;
        m1_b = '0;
        case (i_cmd.phase)
            PH_M0: begin
                m0_a = {15'b0, r_r3};
                m0_b = r_t;
                m1_a = {16'b0, r_t};
                m1_b = r_t;
            end
            PH_M1: begin
                m0_a = {1'b0, r_rt3};
                m0_b = r_r;
                m1_a = {1'b0, r_rt3};
                m1_b = r_t;
            end
            PH_M2: begin
                m0_a = r_tt;
                m0_b = r_t;
                m1_a = {1'b0, r_b1};
                m1_b = coef_a;
            end
            PH_M3: begin
                m1_a = {1'b0, r_b2};
                m1_b = coef_b;
            end
            default: begin
            end
        endcase
    end

    assign m0_p = {17'b0, m0_a} * {33'b0, m0_b};
    assign m1_p = {17'b0, m1_a} * {33'b0, m1_b};

    assign mid_sum = {1'b0, r_top} + {1'b0, r_bottom};
    assign t_n     = mid_sum[17:1];
    assign r_n     = ONE_Q16 - t_n;

    assign sum    = {1'b0, r_acc} + {2'b0, r_pb};
    assign target = {2'b0, r_x, 32'b0};
    assign rnd    = {1'b0, sum} + (52'd1 << 31);
    assign y_q    = rnd[51:32];

    always_ff @(posedge i_clk) begin
        case (i_cmd.phase)
            PH_LOAD: begin
                r_x      <= i_progress;
                r_ax     <= i_ctrl_a_x;
                r_ay     <= i_ctrl_a_y;
                r_bx     <= i_ctrl_b_x;
                r_by     <= i_ctrl_b_y;
                r_lin    <= (i_ctrl_a_x == i_ctrl_a_y) && (i_ctrl_b_x == i_ctrl_b_y);
                r_top    <= ONE_Q16;
                r_bottom <= '0;
            end
            PH_MID: begin
                r_t  <= t_n;
                r_r  <= r_n;
                r_r3 <= {1'b0, r_n} + {r_n, 1'b0};
            end
            PH_M0: begin
                r_rt3 <= m0_p[31:0];
                r_tt  <= m1_p[32:0];
            end
            PH_M1: begin
                r_b1 <= m0_p[47:16];
                r_b2 <= m1_p[47:16];
            end
            PH_M2: begin
                r_b3 <= m0_p[48:16];
                r_pa <= m1_p[48:0];
            end
            PH_M3: begin
                r_pb  <= m1_p[48:0];
                r_acc <= {1'b0, r_pa} + {1'b0, r_b3, 16'b0};
            end
            PH_CMP: begin
                if (sum != target) begin
                    if (sum < target) begin
                        r_bottom <= r_t;
                    end else begin
                        r_top <= r_t;
                    end
                end
            end
            PH_OUT_Y:   r_eased <= (y_q[19:17] != 3'b0) ? '1 : y_q[16:0];
            PH_OUT_LIN: r_eased <= r_x;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.phase == PH_OUT_Y) || (i_cmd.phase == PH_OUT_LIN);
        end
    end

    assign o_stat.lin = r_lin;
    assign o_stat.hit = (sum == target);
    assign o_valid    = r_valid;
    assign o_eased    = r_eased;

    a_bracket_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.phase == PH_CMP) |=> (r_bottom <= r_top))
        else $error("bisection bracket inverted");

    a_no_curve_on_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.phase == PH_OUT_Y) |-> !r_lin)
        else $error("curve result produced for a linear curve");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

endmodule

/* sv/cubic_bezier_ease_bisection_unit.sv */
// Cubic Bezier easing: bisection search for t, then curve y at t, Q1.16.
// A linear curve skips the search and passes progress through; else the search takes k steps
// (k <= ITERATIONS, fewer on an exact hit), then a y pass with the same t.
// Each step runs midpoint, four phases on two shared 33x17 multipliers, then compare.
// One item at a time; busy drops in the cycle the result strobe shows. No result backpressure.
// Synchronous active-low reset returns the sequencer to idle and clears the strobe.
module cubic_bezier_ease_bisection_unit #(
    parameter int ITERATIONS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [cbe_pkg::Q_W-1:0] i_progress,
    input  logic [cbe_pkg::Q_W-1:0] i_ctrl_a_x,
    input  logic [cbe_pkg::Q_W-1:0] i_ctrl_a_y,
    input  logic [cbe_pkg::Q_W-1:0] i_ctrl_b_x,
    input  logic [cbe_pkg::Q_W-1:0] i_ctrl_b_y,
    output logic                    o_valid,
    output logic [cbe_pkg::Q_W-1:0] o_eased
);
    import cbe_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    cbe_ctrl #(
        .ITERATIONS (ITERATIONS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    cbe_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_progress (i_progress),
        .i_ctrl_a_x (i_ctrl_a_x),
        .i_ctrl_a_y (i_ctrl_a_y),
        .i_ctrl_b_x (i_ctrl_b_x),
        .i_ctrl_b_y (i_ctrl_b_y),
        .o_stat     (stat),
        .o_valid    (o_valid),
        .o_eased    (o_eased)
    );

endmodule

/* test/tb_cubic_bezier_ease_bisection_unit.sv */
// Self-checking testbench for cubic_bezier_ease_bisection_unit: drives Q1.16 easing
// requests and compares each strobed result against a bit-exact bisection predictor.
// Depends on cbe_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_cubic_bezier_ease_bisection_unit;
    import cbe_pkg::*;

    localparam int STEPS       = 16;
    localparam int CYCLE_LIMIT = 800_000;
    localparam int N_RANDOM    = 1500;
    localparam int CALM_TAIL   = 200;       // final items sent back to back
    localparam logic [Q_W-1:0] Q_MAX = '1;

    class eased_scoreboard;
        logic [Q_W-1:0] pending_eased[$];
        int             mismatches;

        function new();
            mismatches = 0;
        endfunction

        // curve coordinate at t, Q.48, weighted by the two control values
        function longint unsigned curve_at(longint unsigned t, longint unsigned w1,
                                           longint unsigned w2);
            longint unsigned r, b1, b2, b3;
            r  = longint'(ONE_Q16) - t;
            b1 = (64'd3 * r * r * t) >> 16;
            b2 = (64'd3 * r * t * t) >> 16;
            b3 = (t * t * t) >> 16;
            return b1 * w1 + b2 * w2 + b3 * longint'(ONE_Q16);
        endfunction

        function logic [Q_W-1:0] ease_value(logic [Q_W-1:0] x, logic [Q_W-1:0] ax,
                                            logic [Q_W-1:0] ay, logic [Q_W-1:0] bx,
                                            logic [Q_W-1:0] by);
            longint unsigned target, top, bottom, t, fx, y;
            if (ax == ay && bx == by)
                return x;
            target = longint'(x) << 32;
            top    = longint'(ONE_Q16);
            bottom = 0;
            t      = 0;
            for (int i = 0; i < STEPS; i++) begin
                t  = (top + bottom) >> 1;
                fx = curve_at(t, ax, bx);
                if (fx == target)
                    break;
                if (fx < target)
                    bottom = t;
                else
                    top = t;
            end
            if (t > longint'(ONE_Q16))
                t = longint'(ONE_Q16);
            y = (curve_at(t, ay, by) + (64'd1 << 31)) >> 32;
            if (y > longint'(Q_MAX))
                y = longint'(Q_MAX);
            return y[Q_W-1:0];
        endfunction

        function void note_request(logic [Q_W-1:0] x, logic [Q_W-1:0] ax,
                                   logic [Q_W-1:0] ay, logic [Q_W-1:0] bx,
                                   logic [Q_W-1:0] by);
            pending_eased.push_back(ease_value(x, ax, ay, bx, by));
        endfunction

        function void check_eased(logic [Q_W-1:0] got);
            logic [Q_W-1:0] want;
            if (pending_eased.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d", $time, got);
                mismatches++;
                return;
            end
            want = pending_eased.pop_front();
            if (got !== want) begin
                $display("%0t: eased mismatch, expected %0d, got %0d", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    logic [Q_W-1:0] i_progress;
    logic [Q_W-1:0] i_ctrl_a_x;
    logic [Q_W-1:0] i_ctrl_a_y;
    logic [Q_W-1:0] i_ctrl_b_x;
    logic [Q_W-1:0] i_ctrl_b_y;
    logic           o_valid;
    logic [Q_W-1:0] o_eased;

    eased_scoreboard sb;
    int              cycles = 0;

    cubic_bezier_ease_bisection_unit #(
        .ITERATIONS(STEPS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_progress (i_progress),
        .i_ctrl_a_x (i_ctrl_a_x),
        .i_ctrl_a_y (i_ctrl_a_y),
        .i_ctrl_b_x (i_ctrl_b_x),
        .i_ctrl_b_y (i_ctrl_b_y),
        .o_valid    (o_valid),
        .o_eased    (o_eased)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_eased(o_eased);
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input logic [Q_W-1:0] x, input logic [Q_W-1:0] ax,
                                input logic [Q_W-1:0] ay, input logic [Q_W-1:0] bx,
                                input logic [Q_W-1:0] by);
        bit taken;
        start      = 1'b1;
        i_progress = x;
        i_ctrl_a_x = ax;
        i_ctrl_a_y = ay;
        i_ctrl_b_x = bx;
        i_ctrl_b_y = by;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        sb.note_request(x, ax, ay, bx, by);
        @(negedge i_clk);
    endtask

    task automatic idle_for(input int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [Q_W-1:0] pick_q16();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return Q_MAX;
            3, 4:    return Q_W'($urandom_range(0, 131071));
            default: return Q_W'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        logic [Q_W-1:0] x, ax, ay, bx, by;
        bit             idle_on;

        sb         = new();
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_progress = '0;
        i_ctrl_a_x = '0;
        i_ctrl_a_y = '0;
        i_ctrl_b_x = '0;
        i_ctrl_b_y = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // linear curves, including progress beyond 1.0
        send_request(17'd0, 17'd16384, 17'd16384, 17'd49152, 17'd49152);
        send_request(ONE_Q16, 17'd0, 17'd0, ONE_Q16, ONE_Q16);
        send_request(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_request(17'd12345, 17'd0, 17'd0, 17'd0, 17'd0);
        // standard ease and ease-in-out curves across the progress range
        send_request(17'd0, 17'd16384, 17'd6554, 17'd16384, ONE_Q16);
        send_request(17'd32768, 17'd16384, 17'd6554, 17'd16384, ONE_Q16);
        send_request(ONE_Q16, 17'd16384, 17'd6554, 17'd16384, ONE_Q16);
        send_request(17'd1, 17'd27525, 17'd0, 17'd38011, ONE_Q16);
        send_request(17'd65535, 17'd27525, 17'd0, 17'd38011, ONE_Q16);
        // symmetric curve: exact hit on the first midpoint
        send_request(17'd32768, 17'd16384, 17'd0, 17'd49152, ONE_Q16);
        send_request(17'd32768, 17'd0, ONE_Q16, ONE_Q16, 17'd0);
        // progress out of the curve's reach pins t at the top
        send_request(Q_MAX, 17'd16384, 17'd6554, 17'd16384, ONE_Q16);
        send_request(Q_MAX, 17'd0, Q_MAX, 17'd0, Q_MAX);
        // control points above 1.0, largest y weights
        send_request(17'd40000, Q_MAX, 17'd0, 17'd0, Q_MAX);
        send_request(17'd80000, Q_MAX, Q_MAX, 17'd0, Q_MAX);
        send_request(17'd50000, 17'd0, Q_MAX, Q_MAX, Q_MAX);
        send_request(17'd98304, Q_MAX, 17'd1, Q_MAX, Q_MAX);
        // nearly linear: one bit apart
        send_request(17'd20000, 17'd0, 17'd1, 17'd0, 17'd0);
        send_request(17'd20000, 17'd30000, 17'd30000, 17'd30000, 17'd30001);
        idle_for(3);
        send_request(17'd0, 17'd0, Q_MAX, Q_MAX, 17'd0);
        send_request(17'd65536, Q_MAX, 17'd0, Q_MAX, 17'd0);
        send_request(17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555, 17'h0AAAA);

        idle_on = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            x  = pick_q16();
            ax = pick_q16();
            ay = pick_q16();
            bx = pick_q16();
            by = pick_q16();
            case ($urandom_range(0, 19))
                0, 1: begin                 // linear
                    ay = ax;
                    by = bx;
                end
                2: begin                    // symmetric, hits on the first step
                    ax = Q_W'($urandom_range(0, 65536));
                    bx = ONE_Q16 - ax;
                    x  = 17'd32768;
                end
                3, 4, 5, 6, 7, 8: begin     // typical easing curve
                    x  = Q_W'($urandom_range(0, 65536));
                    ax = Q_W'($urandom_range(0, 65536));
                    bx = Q_W'($urandom_range(0, 65536));
                end
                default: ;
            endcase
            send_request(x, ax, ay, bx, by);
            if (idle_on && n < N_RANDOM - CALM_TAIL && $urandom_range(0, 2) == 0)
                idle_for($urandom_range(1, 8));
        end
        start = 1'b0;

        while (sb.pending_eased.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_eased.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* cubic_bezier_ease_bisection_unit.f */
sv/cbe_pkg.sv
sv/cbe_ctrl.sv
sv/cbe_datapath.sv
sv/cubic_bezier_ease_bisection_unit.sv
test/tb_cubic_bezier_ease_bisection_unit.sv
